/* rtl/core/quadratic_root_solver_macros.svh */
// assertion helpers used by the checker file qrs_check
`ifndef QUADRATIC_ROOT_SOLVER_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_MACROS_SVH

// consequent checked in the same cycle
`define QRS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("quadratic root solver check failed");

// consequent checked in the next cycle
`define QRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("quadratic root solver check failed");

`endif

/* rtl/core/qrs_pkg.sv */
package qrs_pkg;

    localparam int COEF_BITS = 16;
    localparam int FRAC_BITS = 16;
    localparam int OUT_W     = 34;

    localparam int DISC_W = 2 * COEF_BITS + 2;
    localparam int RAD_W  = DISC_W + 2 * FRAC_BITS;
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 3;
    localparam int NB_W   = COEF_BITS + FRAC_BITS + 1;
    localparam int NUM_W  = ((ROOT_W + 1 > NB_W) ? ROOT_W + 1 : NB_W) + 1;
    localparam int MAG_W  = NUM_W;
    localparam int DEN_W  = COEF_BITS + 2;
    localparam int DMAG_W = COEF_BITS + 1;

    typedef enum logic [1:0] {
        KIND_REAL    = 2'd0,
        KIND_DOUBLE  = 2'd1,
        KIND_COMPLEX = 2'd2,
        KIND_LINEAR  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                    kind;
        logic signed [DISC_W-1:0] disc;
        logic signed [NB_W-1:0]   nb;
        logic signed [DEN_W-1:0]  den;
    } eq_side_t;

    typedef struct packed {
        kind_t                    kind;
        logic signed [DISC_W-1:0] disc;
        logic                     neg_one;
        logic                     neg_two;
    } div_side_t;

endpackage

/* rtl/core/qrs_disc.sv */
module qrs_disc
    import qrs_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        in_valid,
    input  logic signed [COEF_BITS-1:0] a,
    input  logic signed [COEF_BITS-1:0] b,
    input  logic signed [COEF_BITS-1:0] c,
    output logic                        out_valid,
    output eq_side_t                    side
);

    logic signed [COEF_BITS-1:0]   a1_reg, b1_reg, c1_reg;
    logic signed [COEF_BITS-1:0]   a2_reg, b2_reg;
    logic signed [2*COEF_BITS-1:0] bb_reg, ac_reg;
    eq_side_t                      side_reg, side_next;
    logic [2:0]                    valid_reg;
    logic signed [DISC_W-1:0]      disc_next;
    logic signed [NB_W-1:0]        nb_ext;

    always_comb
    begin
        disc_next = DISC_W'(bb_reg) - (DISC_W'(ac_reg) <<< 2);
        nb_ext    = NB_W'(b2_reg);
        side_next.disc = disc_next;
        side_next.nb   = -(nb_ext <<< FRAC_BITS);
        side_next.den  = DEN_W'(a2_reg) <<< 1;
        if (a2_reg == '0)
        begin
            side_next.kind = KIND_LINEAR;
        end
        else if (disc_next == '0)
        begin
            side_next.kind = KIND_DOUBLE;
        end
        else if (!disc_next[DISC_W-1])
        begin
            side_next.kind = KIND_REAL;
        end
        else
        begin
            side_next.kind = KIND_COMPLEX;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a1_reg   <= a;
            b1_reg   <= b;
            c1_reg   <= c;
            bb_reg   <= b1_reg * b1_reg;
            ac_reg   <= a1_reg * c1_reg;
            a2_reg   <= a1_reg;
            b2_reg   <= b1_reg;
            side_reg <= side_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    assign out_valid = valid_reg[2];
    assign side      = side_reg;

endmodule

/* rtl/core/qrs_sqrt.sv */
module qrs_sqrt
    import qrs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  eq_side_t          side_in,
    output logic              out_valid,
    output eq_side_t          side_out,
    output logic [ROOT_W-1:0] root
);

    logic [DISC_W-1:0] mag_reg;
    logic [RAD_W-1:0]  rad_reg  [0:ROOT_W];
    logic [REM_W-1:0]  rem_reg  [0:ROOT_W];
    logic [ROOT_W-1:0] root_reg [0:ROOT_W];
    eq_side_t          side_reg [0:ROOT_W];
    logic [ROOT_W:0]   valid_reg;

    // stage zero: magnitude of the discriminant, scaled by the fraction bits
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag_reg     <= side_in.disc[DISC_W-1] ? DISC_W'(-side_in.disc)
                                                  : DISC_W'(side_in.disc);
            side_reg[0] <= side_in;
        end
    end

    assign rad_reg[0]  = {mag_reg, {(2*FRAC_BITS){1'b0}}};
    assign rem_reg[0]  = '0;
    assign root_reg[0] = '0;

    // one result bit per stage
    for (genvar k = 1; k <= ROOT_W; k++)
    begin : g_step
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        logic             take;

        assign rem_sh = {rem_reg[k-1][REM_W-3:0], rad_reg[k-1][RAD_W-1 -: 2]};
        assign trial  = {1'b0, root_reg[k-1], 2'b01};
        assign take   = (rem_sh >= trial);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rad_reg[k]  <= rad_reg[k-1] << 2;
                rem_reg[k]  <= take ? (rem_sh - trial) : rem_sh;
                root_reg[k] <= {root_reg[k-1][ROOT_W-2:0], take};
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[ROOT_W-1:0], in_valid};
        end
    end

    assign out_valid = valid_reg[ROOT_W];
    assign side_out  = side_reg[ROOT_W];
    assign root      = root_reg[ROOT_W];

endmodule

/* rtl/core/qrs_div.sv */
module qrs_div
    import qrs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  eq_side_t          side_in,
    input  logic [ROOT_W-1:0] root,
    output logic              out_valid,
    output div_side_t         side_out,
    output logic [MAG_W-1:0]  q_one,
    output logic [MAG_W-1:0]  q_two
);

    logic signed [NUM_W-1:0] n1_reg, n2_reg;
    logic signed [NUM_W-1:0] nb_ext, s_ext;
    logic signed [DEN_W-1:0] den_reg;
    kind_t                   kind_reg;
    logic signed [DISC_W-1:0] disc_reg;
    logic                    va_reg;

    logic [MAG_W-1:0]  dq1_reg  [0:MAG_W];
    logic [MAG_W-1:0]  dq2_reg  [0:MAG_W];
    logic [DMAG_W:0]   rem1_reg [0:MAG_W];
    logic [DMAG_W:0]   rem2_reg [0:MAG_W];
    logic [DMAG_W-1:0] dmag_reg [0:MAG_W];
    div_side_t         dside_reg [0:MAG_W];
    logic [MAG_W:0]    valid_reg;

    assign nb_ext = NUM_W'(side_in.nb);
    assign s_ext  = NUM_W'($signed({1'b0, root}));

    // numerators: complex pair divides the real and imaginary parts apart
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n1_reg   <= (side_in.kind == KIND_COMPLEX) ? nb_ext : (nb_ext - s_ext);
            n2_reg   <= (side_in.kind == KIND_COMPLEX) ? s_ext : (nb_ext + s_ext);
            den_reg  <= side_in.den;
            kind_reg <= side_in.kind;
            disc_reg <= side_in.disc;
        end
    end

    // magnitudes and result signs, truncation toward zero
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dq1_reg[0]  <= n1_reg[NUM_W-1] ? MAG_W'(-n1_reg) : MAG_W'(n1_reg);
            dq2_reg[0]  <= n2_reg[NUM_W-1] ? MAG_W'(-n2_reg) : MAG_W'(n2_reg);
            dmag_reg[0] <= den_reg[DEN_W-1] ? DMAG_W'(-den_reg) : DMAG_W'(den_reg);
            dside_reg[0].kind    <= kind_reg;
            dside_reg[0].disc    <= disc_reg;
            dside_reg[0].neg_one <= n1_reg[NUM_W-1] ^ den_reg[DEN_W-1];
            dside_reg[0].neg_two <= n2_reg[NUM_W-1] ^ den_reg[DEN_W-1];
        end
    end

    assign rem1_reg[0] = '0;
    assign rem2_reg[0] = '0;

    // restoring division, one quotient bit per stage in both lanes
    for (genvar k = 1; k <= MAG_W; k++)
    begin : g_step
        logic [DMAG_W:0] sh1, sh2, dv;
        logic            ge1, ge2;

        assign dv  = {1'b0, dmag_reg[k-1]};
        assign sh1 = {rem1_reg[k-1][DMAG_W-1:0], dq1_reg[k-1][MAG_W-1]};
        assign sh2 = {rem2_reg[k-1][DMAG_W-1:0], dq2_reg[k-1][MAG_W-1]};
        assign ge1 = (sh1 >= dv);
        assign ge2 = (sh2 >= dv);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem1_reg[k]  <= ge1 ? (sh1 - dv) : sh1;
                rem2_reg[k]  <= ge2 ? (sh2 - dv) : sh2;
                dq1_reg[k]   <= {dq1_reg[k-1][MAG_W-2:0], ge1};
                dq2_reg[k]   <= {dq2_reg[k-1][MAG_W-2:0], ge2};
                dmag_reg[k]  <= dmag_reg[k-1];
                dside_reg[k] <= dside_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg    <= 1'b0;
            valid_reg <= '0;
        end
        else if (adv)
        begin
            va_reg    <= in_valid;
            valid_reg <= {valid_reg[MAG_W-1:0], va_reg};
        end
    end

    assign out_valid = valid_reg[MAG_W];
    assign side_out  = dside_reg[MAG_W];
    assign q_one     = dq1_reg[MAG_W];
    assign q_two     = dq2_reg[MAG_W];

endmodule

/* rtl/core/quadratic_root_solver.sv */
// channel   | handshake            | payload
// request   | req_valid, req_stall | coef_a, coef_b, coef_c
// result    | res_valid, res_stall | root_kind, root_one, root_two, discriminant
//
// one request enters every cycle while the result is not stalled;
// the pipeline has one stage per bit of the square root and of each quotient
// rst_n clears only the valid bits; the data path carries no reset
// a stalled result freezes the whole pipeline, and req_stall follows it directly
module quadratic_root_solver
    import qrs_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  logic signed [COEF_BITS-1:0] coef_a,
    input  logic signed [COEF_BITS-1:0] coef_b,
    input  logic signed [COEF_BITS-1:0] coef_c,
    output logic                        res_valid,
    input  logic                        res_stall,
    output logic [1:0]                  root_kind,
    output logic signed [OUT_W-1:0]     root_one,
    output logic signed [OUT_W-1:0]     root_two,
    output logic signed [OUT_W-1:0]     discriminant
);

    logic              adv;
    logic              disc_valid, sqrt_valid, div_valid;
    eq_side_t          disc_side, sqrt_side;
    div_side_t         div_side;
    logic [ROOT_W-1:0] sqrt_root;
    logic [MAG_W-1:0]  q_one, q_two;
    logic signed [MAG_W-1:0] r1_full, r2_full;

    logic                    res_valid_reg;
    logic [1:0]              kind_reg;
    logic signed [OUT_W-1:0] one_reg, two_reg, disc_reg;

    assign adv       = !(res_valid_reg && res_stall);
    assign req_stall = !adv;

    qrs_disc u_disc (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (req_valid),
        .a         (coef_a),
        .b         (coef_b),
        .c         (coef_c),
        .out_valid (disc_valid),
        .side      (disc_side)
    );

    qrs_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (disc_valid),
        .side_in   (disc_side),
        .out_valid (sqrt_valid),
        .side_out  (sqrt_side),
        .root      (sqrt_root)
    );

    qrs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sqrt_valid),
        .side_in   (sqrt_side),
        .root      (sqrt_root),
        .out_valid (div_valid),
        .side_out  (div_side),
        .q_one     (q_one),
        .q_two     (q_two)
    );

    assign r1_full = div_side.neg_one ? -$signed(q_one) : $signed(q_one);
    assign r2_full = div_side.neg_two ? -$signed(q_two) : $signed(q_two);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kind_reg <= div_side.kind;
            disc_reg <= OUT_W'(div_side.disc);
            // zero divisor when not quadratic, roots forced to zero
            one_reg  <= (div_side.kind == KIND_LINEAR) ? '0 : OUT_W'(r1_full);
            two_reg  <= (div_side.kind == KIND_LINEAR) ? '0 : OUT_W'(r2_full);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            res_valid_reg <= div_valid;
        end
    end

    assign res_valid    = res_valid_reg;
    assign root_kind    = kind_reg;
    assign root_one     = one_reg;
    assign root_two     = two_reg;
    assign discriminant = disc_reg;

endmodule

/* rtl/core/qrs_check.sv */
`include "quadratic_root_solver_macros.svh"

module qrs_check
    import qrs_pkg::*;
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_stall,
    input logic                        res_valid,
    input logic                        res_stall,
    input logic [1:0]                  root_kind,
    input logic signed [OUT_W-1:0]     root_one,
    input logic signed [OUT_W-1:0]     root_two,
    input logic signed [OUT_W-1:0]     discriminant
);

    `QRS_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(root_one) && $stable(root_two))
    `QRS_ASSERT_NOW(a_backpressure, res_valid && res_stall, req_stall)
    `QRS_ASSERT_NOW(a_linear_zero, res_valid && root_kind == KIND_LINEAR, root_one == '0 && root_two == '0)
    `QRS_ASSERT_NOW(a_double_same, res_valid && root_kind == KIND_DOUBLE, discriminant == '0 && root_one == root_two)
    `QRS_ASSERT_NOW(a_complex_neg, res_valid && root_kind == KIND_COMPLEX, discriminant[OUT_W-1])

endmodule

bind quadratic_root_solver qrs_check u_check (.*);

/* verif/qrs_checker.sv */
module qrs_checker
    import qrs_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    input  logic                        req_stall,
    input  logic signed [COEF_BITS-1:0] coef_a,
    input  logic signed [COEF_BITS-1:0] coef_b,
    input  logic signed [COEF_BITS-1:0] coef_c,
    input  logic                        res_valid,
    input  logic                        res_stall,
    input  logic [1:0]                  root_kind,
    input  logic signed [OUT_W-1:0]     root_one,
    input  logic signed [OUT_W-1:0]     root_two,
    input  logic signed [OUT_W-1:0]     discriminant,
    output int                          fail_count,
    output int                          pending,
    output int                          kind_seen [4]
);

    typedef struct packed {
        kind_t             kind;
        logic [OUT_W-1:0]  one;
        logic [OUT_W-1:0]  two;
        logic [OUT_W-1:0]  disc;
    } roots_t;

    roots_t roots_queue[$];

    // floor(sqrt(d * 4^FRAC_BITS)) without overflowing 64 bits
    function automatic longint fixed_sqrt(bit [63:0] d);
        bit [63:0] r;
        bit [63:0] rem;
        bit [63:0] t;
        r = 0;
        for (int k = 31; k >= 0; k--)
        begin
            t = r | (64'd1 << k);
            if (t * t <= d)
                r = t;
        end
        rem = d - r * r;
        for (int i = 0; i < FRAC_BITS; i++)
        begin
            t = 4 * r + 1;
            rem = rem * 4;
            if (rem >= t)
            begin
                rem = rem - t;
                r = 2 * r + 1;
            end
            else
                r = 2 * r;
        end
        return longint'(r);
    endfunction

    function automatic roots_t solve_roots(longint a, longint b, longint c);
        roots_t res;
        longint disc;
        longint den;
        longint nb;
        longint s;
        longint r1;
        longint r2;
        disc = b * b - 4 * a * c;
        r1 = 0;
        r2 = 0;
        if (a == 0)
            res.kind = KIND_LINEAR;
        else
        begin
            den = 2 * a;
            nb = -b * (longint'(1) << FRAC_BITS);
            s = fixed_sqrt((disc < 0) ? -disc : disc);
            if (disc == 0)
            begin
                res.kind = KIND_DOUBLE;
                r1 = nb / den;
                r2 = r1;
            end
            else if (disc > 0)
            begin
                res.kind = KIND_REAL;
                r1 = (nb - s) / den;
                r2 = (nb + s) / den;
            end
            else
            begin
                res.kind = KIND_COMPLEX;
                r1 = nb / den;
                r2 = s / den;
            end
        end
        res.one = r1[OUT_W-1:0];
        res.two = r2[OUT_W-1:0];
        res.disc = disc[OUT_W-1:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        roots_t want;
        if (!rst_n)
        begin
            fail_count <= 0;
            pending <= 0;
            roots_queue.delete();
            for (int k = 0; k < 4; k++)
                kind_seen[k] <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
                roots_queue.push_back(solve_roots(coef_a, coef_b, coef_c));
            if (res_valid && !res_stall)
            begin
                if (roots_queue.size() == 0)
                begin
                    $error("result with no request outstanding");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = roots_queue.pop_front();
                    kind_seen[want.kind] <= kind_seen[want.kind] + 1;
                    if (root_kind != want.kind || root_one != want.one
                        || root_two != want.two || discriminant != want.disc)
                        fail_count <= fail_count + 1;
                    if (root_kind != want.kind)
                        $error("root_kind expected %0d actual %0d", want.kind, root_kind);
                    if (root_one != want.one)
                        $error("root_one expected %0d actual %0d",
                               $signed(want.one), root_one);
                    if (root_two != want.two)
                        $error("root_two expected %0d actual %0d",
                               $signed(want.two), root_two);
                    if (discriminant != want.disc)
                        $error("discriminant expected %0d actual %0d",
                               $signed(want.disc), discriminant);
                end
            end
            pending <= roots_queue.size();
        end
    end

endmodule

/* verif/tb_quadratic_root_solver.sv */
module tb_quadratic_root_solver;
    import qrs_pkg::*;

    localparam int RANDOM_COUNT = 1950;
    localparam int IDLE_LIMIT   = 20000;

    logic                        clk;
    logic                        rst_n;
    logic                        req_valid;
    logic                        req_stall;
    logic signed [COEF_BITS-1:0] coef_a;
    logic signed [COEF_BITS-1:0] coef_b;
    logic signed [COEF_BITS-1:0] coef_c;
    logic                        res_valid;
    logic                        res_stall = 1'b0;
    logic [1:0]                  root_kind;
    logic signed [OUT_W-1:0]     root_one;
    logic signed [OUT_W-1:0]     root_two;
    logic signed [OUT_W-1:0]     discriminant;
    int                          fail_count;
    int                          pending;
    int                          kind_seen [4];
    int                          idle_cycles;
    int                          sent_count;
    int                          stall_mode = 0;

    quadratic_root_solver u_top (.*);

    qrs_checker u_checker (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // watchdog: no handshake on either channel for too long
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (res_valid && !res_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog expired with %0d results outstanding", pending);
            $display("quadratic_root_solver verification failed");
            $finish;
        end
    end

    // receiver stall pattern, switching between free, light and heavy
    always @(negedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: res_stall <= 1'b0;
            1: res_stall <= ($urandom_range(0, 3) == 0);
            default: res_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    task automatic send_request(int a, int b, int c);
        req_valid <= 1'b1;
        coef_a <= COEF_BITS'(a);
        coef_b <= COEF_BITS'(b);
        coef_c <= COEF_BITS'(c);
        do
            @(posedge clk);
        while (req_stall);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic pause_sender();
        int gap;
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic random_request();
        int a;
        int b;
        int c;
        int r;
        case ($urandom_range(0, 9))
            0:
            begin
                a = 0;
                b = $signed(16'($urandom));
                c = $signed(16'($urandom));
            end
            1, 2:
            begin
                // repeated root: a*(x - r)^2
                a = $urandom_range(1, 40) * ($urandom_range(0, 1) ? 1 : -1);
                r = $urandom_range(0, 25) - 12;
                b = -2 * a * r;
                c = a * r * r;
            end
            3, 4:
            begin
                a = $urandom_range(0, 30) - 15;
                b = $urandom_range(0, 60) - 30;
                c = $urandom_range(0, 30) - 15;
            end
            5:
            begin
                a = $urandom_range(0, 1) ? 32767 : -32768;
                b = $signed(16'($urandom));
                c = $urandom_range(0, 1) ? 32767 : -32768;
            end
            default:
            begin
                a = $signed(16'($urandom));
                b = $signed(16'($urandom));
                c = $signed(16'($urandom));
            end
        endcase
        send_request(a, b, c);
    endtask

    initial
    begin
        int burst;
        rst_n = 1'b0;
        req_valid = 1'b0;
        coef_a = '0;
        coef_b = '0;
        coef_c = '0;
        sent_count = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: extremes, each kind, repeated roots, sign of a
        send_request(0, 0, 0);
        send_request(0, -32768, 32767);
        send_request(0, 32767, -32768);
        send_request(1, 0, 0);
        send_request(1, -2, 1);
        send_request(-1, 2, -1);
        send_request(1, 0, -1);
        send_request(1, 0, 1);
        send_request(-1, 0, -1);
        send_request(-32768, -32768, 32767);
        send_request(32767, -32768, -32768);
        send_request(-32768, 0, -32768);
        send_request(32767, 0, 32767);
        send_request(-32768, 32767, 32767);
        send_request(32767, 32767, 32767);
        send_request(-32768, -32768, -32768);
        send_request(1, 32767, 0);
        send_request(-1, -32768, 0);
        send_request(2, 3, 1);
        send_request(-3, 5, 7);
        send_request(3, 5, 7);
        send_request(16384, -32768, 16384);
        pause_sender();

        while (sent_count < RANDOM_COUNT + 22)
        begin
            burst = $urandom_range(1, 40);
            repeat (burst) random_request();
            pause_sender();
        end
        req_valid <= 1'b0;

        wait (pending == 0);
        repeat (100) @(posedge clk);
        $display("sent %0d requests: %0d two real, %0d repeated, %0d complex, %0d linear",
                 sent_count, kind_seen[KIND_REAL], kind_seen[KIND_DOUBLE],
                 kind_seen[KIND_COMPLEX], kind_seen[KIND_LINEAR]);
        if (fail_count == 0)
            $display("quadratic_root_solver verification clean");
        else
            $display("quadratic_root_solver verification failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/qrs_pkg.sv
rtl/core/qrs_disc.sv
rtl/core/qrs_sqrt.sv
rtl/core/qrs_div.sv
rtl/core/quadratic_root_solver.sv
rtl/core/qrs_check.sv
verif/qrs_checker.sv
verif/tb_quadratic_root_solver.sv
